### hw/rtl/wsd_pkg.sv
// Shared types for the WebSocket frame deframer.
package wsd_pkg;

  // Parse phases. The unused codes behave as expecting the first header byte.
  typedef enum logic [2:0] {
    PhHdr0    = 3'd0,
    PhHdr1    = 3'd1,
    PhExtLen  = 3'd2,
    PhMask    = 3'd3,
    PhPayload = 3'd4
  } phase_e;

  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;
  localparam logic [3:0] Ext16Bytes = 4'd2;
  localparam logic [3:0] Ext64Bytes = 4'd8;
  localparam logic [2:0] KeyBytes = 3'd4;

  // One result item handed from the parser to the output register.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       last_of_frame;
    logic       empty_frame;
  } result_t;

endpackage

### hw/rtl/wsd_parser.sv
// Frame header parser and payload unmasking with its parse state registers.
module wsd_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_valid_i,
  input  logic [7:0]         byte_i,
  output logic               res_valid_o,
  output wsd_pkg::result_t   res_o
);

  wsd_pkg::phase_e phase_q, phase_d;
  logic [3:0]  ext_left_q, ext_left_d;
  logic [63:0] rem_len_q, rem_len_d;
  logic [31:0] mask_key_q, mask_key_d;
  logic [2:0]  mask_left_q, mask_left_d;
  logic [1:0]  key_pos_q, key_pos_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        masked_q, masked_d;

  logic [6:0]  len7;
  logic [7:0]  key_byte;
  logic [4:0]  key_sel;

  assign len7    = byte_i[6:0];
  // Key byte zero sits in the top byte of the key register.
  assign key_sel = {~key_pos_q, 3'b000};
  assign key_byte = masked_q ? mask_key_q[key_sel +: 8] : 8'h00;

  always_comb begin
    phase_d     = phase_q;
    ext_left_d  = ext_left_q;
    rem_len_d   = rem_len_q;
    mask_key_d  = mask_key_q;
    mask_left_d = mask_left_q;
    key_pos_d   = key_pos_q;
    opcode_d    = opcode_q;
    masked_d    = masked_q;
    res_valid_o = 1'b0;
    res_o.payload_byte  = 8'h00;
    res_o.frame_opcode  = opcode_q;
    res_o.last_of_frame = 1'b1;
    res_o.empty_frame   = 1'b1;

    case (phase_q)
      wsd_pkg::PhHdr1: begin
        masked_d = byte_i[7];
        if (len7 == wsd_pkg::Len16Code) begin
          rem_len_d  = '0;
          ext_left_d = wsd_pkg::Ext16Bytes;
          phase_d    = wsd_pkg::PhExtLen;
        end else if (len7 == wsd_pkg::Len64Code) begin
          rem_len_d  = '0;
          ext_left_d = wsd_pkg::Ext64Bytes;
          phase_d    = wsd_pkg::PhExtLen;
        end else begin
          rem_len_d = {57'd0, len7};
          if (byte_i[7]) begin
            mask_left_d = wsd_pkg::KeyBytes;
            mask_key_d  = '0;
            phase_d     = wsd_pkg::PhMask;
          end else begin
            key_pos_d = 2'd0;
            if (len7 == 7'd0) begin
              phase_d     = wsd_pkg::PhHdr0;
              res_valid_o = 1'b1;
            end else begin
              phase_d = wsd_pkg::PhPayload;
            end
          end
        end
      end
      wsd_pkg::PhExtLen: begin
        rem_len_d  = {rem_len_q[55:0], byte_i};
        ext_left_d = ext_left_q - 4'd1;
        if (ext_left_d == 4'd0) begin
          if (masked_q) begin
            mask_left_d = wsd_pkg::KeyBytes;
            mask_key_d  = '0;
            phase_d     = wsd_pkg::PhMask;
          end else begin
            key_pos_d = 2'd0;
            if (rem_len_d == 64'd0) begin
              phase_d     = wsd_pkg::PhHdr0;
              res_valid_o = 1'b1;
            end else begin
              phase_d = wsd_pkg::PhPayload;
            end
          end
        end
      end
      wsd_pkg::PhMask: begin
        mask_key_d  = {mask_key_q[23:0], byte_i};
        mask_left_d = mask_left_q - 3'd1;
        if (mask_left_d == 3'd0) begin
          key_pos_d = 2'd0;
          if (rem_len_q == 64'd0) begin
            phase_d     = wsd_pkg::PhHdr0;
            res_valid_o = 1'b1;
          end else begin
            phase_d = wsd_pkg::PhPayload;
          end
        end
      end
      wsd_pkg::PhPayload: begin
        key_pos_d   = key_pos_q + 2'd1;
        rem_len_d   = rem_len_q - 64'd1;
        res_valid_o = 1'b1;
        res_o.payload_byte  = byte_i ^ key_byte;
        res_o.last_of_frame = (rem_len_d == 64'd0);
        res_o.empty_frame   = 1'b0;
        if (rem_len_d == 64'd0) begin
          phase_d = wsd_pkg::PhHdr0;
        end
      end
      default: begin
        opcode_d = byte_i[3:0];
        phase_d  = wsd_pkg::PhHdr1;
      end
    endcase

    if (!byte_valid_i) begin
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= wsd_pkg::PhHdr0;
      ext_left_q  <= '0;
      rem_len_q   <= '0;
      mask_key_q  <= '0;
      mask_left_q <= '0;
      key_pos_q   <= '0;
      opcode_q    <= '0;
      masked_q    <= 1'b0;
    end else if (byte_valid_i) begin
      phase_q     <= phase_d;
      ext_left_q  <= ext_left_d;
      rem_len_q   <= rem_len_d;
      mask_key_q  <= mask_key_d;
      mask_left_q <= mask_left_d;
      key_pos_q   <= key_pos_d;
      opcode_q    <= opcode_d;
      masked_q    <= masked_d;
    end
  end

endmodule

### hw/rtl/websocket_frame_deframer.sv
// Top level of the WebSocket frame deframer: byte stream in, unmasked payload stream out.
// A payload byte or empty-frame marker appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the receiver stalls; parse state and 64-bit length
// count update in the accept cycle, so header, key and payload bytes stream without gaps.
// Header, length and key bytes produce no output request, except that the byte completing
// the header of a zero-length frame produces the empty-frame marker.
// Reset (rst_ni low, asynchronous) returns the parser to the first header byte and empties
// the output register.
module websocket_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] payload_byte, [11:8] frame_opcode, rest zero
  output logic        m_axis_tlast_o,   // last_of_frame
  output logic        m_axis_tuser_o    // [0] empty_frame
);

  logic             in_accept;
  logic             res_valid;
  wsd_pkg::result_t res;
  logic             out_valid_q, out_valid_d;
  wsd_pkg::result_t out_q;

  // The output register parts the two sides: a new byte is taken whenever the
  // register is empty or its request is being taken in this same cycle.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  wsd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_accept),
    .byte_i       (s_axis_tdata_i),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload register: loaded only with a new result, so it holds while stalled.
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {4'h0, out_q.frame_opcode, out_q.payload_byte};
  assign m_axis_tlast_o  = out_q.last_of_frame;
  assign m_axis_tuser_o  = out_q.empty_frame;

  // An empty-frame marker always closes its frame and carries a zero byte.
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tlast_o && m_axis_tdata_o[7:0] == 8'h00))
    else $error("empty-frame marker without last or with nonzero byte");

  // A result produced by an accepted byte is presented in the next cycle.
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> m_axis_tvalid_o)
    else $error("parser result lost");

  // The parser never produces a result without an accepted byte.
  a_result_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> in_accept)
    else $error("result without accepted byte");

endmodule

### tb/websocket_frame_deframer_monitor.sv
// Stream monitor for the WebSocket frame deframer: predicts payload results and compares them.
`timescale 1ns / 100ps

module websocket_frame_deframer_monitor
  import wsd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [15:0] m_axis_tdata_i,   // [7:0] payload_byte, [11:8] frame_opcode
  input  logic        m_axis_tlast_i,   // last_of_frame
  input  logic        m_axis_tuser_i,   // [0] empty_frame
  output int          mismatch_count_o,
  output int          outstanding_o
);

  // Parser state as the frame stream has been seen so far.
  phase_e           parse_phase;
  logic [3:0]       ext_left;
  logic [63:0]      length_left;
  logic [3:0][7:0]  mask_key;
  logic [2:0]       key_left;
  logic [1:0]       key_pos;
  logic [3:0]       held_opcode;
  logic             is_masked;

  result_t          due_results[$];
  result_t          predicted;
  int               mismatches = 0;

  assign mismatch_count_o = mismatches;

  // Header fully read: either an empty-frame marker or the start of the payload.
  function automatic bit finish_header(inout result_t r);
    key_pos = 2'd0;
    if (length_left == 64'd0) begin
      parse_phase = PhHdr0;
      r.payload_byte = 8'h00;
      r.last_of_frame = 1'b1;
      r.empty_frame = 1'b1;
      return 1'b1;
    end
    parse_phase = PhPayload;
    return 1'b0;
  endfunction

  // Length fully read: fetch the key first when the frame is masked.
  function automatic bit finish_length(inout result_t r);
    if (is_masked) begin
      key_left = KeyBytes;
      mask_key = '0;
      parse_phase = PhMask;
      return 1'b0;
    end
    return finish_header(r);
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, output result_t r);
    bit emit;
    emit = 1'b0;
    r = '0;
    case (parse_phase)
      PhHdr1: begin
        is_masked = b[7];
        length_left = '0;
        if (b[6:0] == Len16Code) begin
          ext_left = Ext16Bytes;
          parse_phase = PhExtLen;
        end else if (b[6:0] == Len64Code) begin
          ext_left = Ext64Bytes;
          parse_phase = PhExtLen;
        end else begin
          length_left = {57'd0, b[6:0]};
          emit = finish_length(r);
        end
      end
      PhExtLen: begin
        length_left = {length_left[55:0], b};
        ext_left = ext_left - 4'd1;
        if (ext_left == 4'd0) emit = finish_length(r);
      end
      PhMask: begin
        mask_key = {mask_key[2:0], b};
        key_left = key_left - 3'd1;
        if (key_left == 3'd0) emit = finish_header(r);
      end
      PhPayload: begin
        // The first key byte sits in the top lane and pairs with payload index 0.
        r.payload_byte = is_masked ? (b ^ mask_key[2'd3 - key_pos]) : b;
        key_pos = key_pos + 2'd1;
        length_left = length_left - 64'd1;
        r.last_of_frame = (length_left == 64'd0);
        if (r.last_of_frame) parse_phase = PhHdr0;
        emit = 1'b1;
      end
      default: begin
        held_opcode = b[3:0];
        parse_phase = PhHdr1;
      end
    endcase
    r.frame_opcode = held_opcode;
    return emit;
  endfunction

  task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %02h, actual %02h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual tdata %04h last %b user %b",
               $time, m_axis_tdata_i, m_axis_tlast_i, m_axis_tuser_i);
      mismatches++;
    end else begin
      want = due_results.pop_front();
      report_field("payload_byte", want.payload_byte, m_axis_tdata_i[7:0]);
      report_field("frame_opcode", {4'd0, want.frame_opcode}, {4'd0, m_axis_tdata_i[11:8]});
      report_field("last_of_frame", {7'd0, want.last_of_frame}, {7'd0, m_axis_tlast_i});
      report_field("empty_frame", {7'd0, want.empty_frame}, {7'd0, m_axis_tuser_i});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_phase = PhHdr0;
      ext_left = '0;
      length_left = '0;
      mask_key = '0;
      key_left = '0;
      key_pos = '0;
      held_opcode = '0;
      is_masked = 1'b0;
      due_results.delete();
    end else begin
      // A result leaving now belongs to an older request, so compare before predicting.
      if (m_axis_tvalid_i && m_axis_tready_i) check_result();
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        if (parse_byte(s_axis_tdata_i, predicted)) due_results.push_back(predicted);
      end
    end
    outstanding_o = due_results.size();
  end

endmodule

### tb/websocket_frame_deframer_tb.sv
// Top of the deframer testbench: clock, reset, frame stimulus, traffic shaping and verdict.
`timescale 1ns / 100ps

module websocket_frame_deframer_tb;
  import wsd_pkg::*;

  // How the payload length is encoded in the second header byte.
  typedef enum int {
    LenShort,
    LenExt16,
    LenExt64
  } len_form_e;

  localparam int unsigned RandomBytes = 1300;

  logic        clk;
  logic        rst_n;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // [7:0] in_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;    // [7:0] payload_byte, [11:8] frame_opcode, rest zero
  logic        m_axis_tlast;    // last_of_frame
  logic        m_axis_tuser;    // [0] empty_frame

  int          mismatch_count;
  int          outstanding;
  int unsigned idle_pct = 0;    // chance in percent that the sender skips a cycle
  int unsigned stall_pct = 0;   // chance in percent that the receiver holds off
  int unsigned bytes_sent = 0;

  websocket_frame_deframer DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  websocket_frame_deframer_monitor payload_monitor (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .s_axis_tvalid_i  (s_axis_tvalid),
    .s_axis_tready_i  (s_axis_tready),
    .s_axis_tdata_i   (s_axis_tdata),
    .m_axis_tvalid_i  (m_axis_tvalid),
    .m_axis_tready_i  (m_axis_tready),
    .m_axis_tdata_i   (m_axis_tdata),
    .m_axis_tlast_i   (m_axis_tlast),
    .m_axis_tuser_i   (m_axis_tuser),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offers one byte and returns at the falling edge after its request was taken. While the
  // sender idles, the data lines carry junk so that the block cannot rely on them.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata = 8'($urandom_range(255));
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Sends one frame: header byte, length byte, extended length big-endian, the key when
  // masked, then count random payload bytes. count is normally the length itself.
  task automatic send_frame(input logic [3:0] opcode, input logic [3:0] flags,
                            input bit masked, input len_form_e form, input logic [63:0] len,
                            input logic [31:0] key, input int unsigned count);
    logic [6:0] len7;
    int         n_ext;
    len7 = (form == LenExt16) ? Len16Code : (form == LenExt64) ? Len64Code : len[6:0];
    n_ext = (form == LenExt16) ? int'(Ext16Bytes) : (form == LenExt64) ? int'(Ext64Bytes) : 0;
    send_byte({flags, opcode});
    send_byte({masked, len7});
    for (int i = n_ext - 1; i >= 0; i--) send_byte(len[8*i +: 8]);
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(key[8*i +: 8]);
    end
    for (int unsigned i = 0; i < count; i++) send_byte(8'($urandom_range(255)));
  endtask

  // Receiver side: ready is redrawn every cycle from the current stall rate.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      m_axis_tready = ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    logic [3:0]  opcode;
    logic [3:0]  flags;
    bit          masked;
    len_form_e   form;
    logic [63:0] len;
    int unsigned pick;
    int unsigned random_start;
    int unsigned phase;

    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'h00;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed frames, no idling: unmasked payload passes through, a masked frame with a
    // single byte, and zero lengths given in the 16-bit and 64-bit extended forms.
    send_frame(4'hF, 4'h8, 1'b0, LenShort, 64'd2, 32'h0, 2);
    send_frame(4'h0, 4'h7, 1'b1, LenShort, 64'd1, 32'hFF00A55A, 1);
    send_frame(4'h9, 4'h8, 1'b0, LenExt16, 64'd0, 32'h0, 0);
    send_frame(4'hA, 4'h0, 1'b0, LenExt64, 64'd0, 32'h0, 0);

    // Random well-formed frames. The run is split into four traffic phases: free flow,
    // a lazy sender, a stalling receiver, and both at once.
    random_start = bytes_sent;
    while (bytes_sent - random_start < RandomBytes) begin
      phase = (bytes_sent - random_start) * 4 / RandomBytes;
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 59;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 59;
        end
        default: begin
          idle_pct = 30;
          stall_pct = 30;
        end
      endcase
      opcode = 4'($urandom_range(15));
      flags = 4'($urandom_range(15));
      masked = 1'($urandom_range(1));
      pick = $urandom_range(99);
      form = (pick < 60) ? LenShort : (pick < 85) ? LenExt16 : LenExt64;
      pick = $urandom_range(99);
      if (pick < 12) len = 64'd0;
      else if (pick < 88) len = 64'($urandom_range(12, 1));
      else len = 64'($urandom_range(300, 13));
      if (form == LenShort && len > 64'd125) len = 64'd125;
      send_frame(opcode, flags, masked, form, len, $urandom, int'(len));
    end

    // A 64-bit length with its top bit set is taken as is, so the frame never ends here:
    // every byte after the header must come out unmasked and without the last mark.
    len = {1'b1, 31'($urandom), 32'($urandom)};
    send_frame(4'($urandom_range(15)), 4'($urandom_range(15)), 1'b1, LenExt64, len,
               $urandom, 40);

    s_axis_tvalid = 1'b0;
    stall_pct = 0;
    while (outstanding != 0) @(posedge clk);
    // Once nothing is outstanding, wait on for any stray results before the verdict.
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
